[hw/rtl/keypad_card_door_lock_top_defines.svh]
// ----------------------------------------------------------------------------
// Door lock assertion macros
// Shared concurrent assertion forms used by the door lock RTL.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CARD_DOOR_LOCK_TOP_DEFINES_SVH
`define KEYPAD_CARD_DOOR_LOCK_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define KCDL_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check a consequence at the clock after a condition.
`define KCDL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/kcdl_pkg.sv]
// ----------------------------------------------------------------------------
// Door lock package
// Field widths, codes and payload types shared by the door lock RTL.
// ----------------------------------------------------------------------------
package kcdl_pkg;

    localparam int OP_W      = 2;
    localparam int KEY_W     = 4;
    localparam int UID_W     = 32;
    localparam int MODE_W    = 3;
    localparam int MISS_W    = 4;
    localparam int ENTRY_W   = 4;
    localparam int EVENT_W   = 3;
    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int CODE_RST_DIGITS = 6;

    typedef enum logic [OP_W-1:0] {
        OP_KEY  = 2'd0,
        OP_TICK = 2'd1,
        OP_CARD = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [KEY_W-1:0] KEY_CLEAR     = 4'd10;
    localparam logic [KEY_W-1:0] KEY_BACK      = 4'd11;
    localparam logic [KEY_W-1:0] KEY_CHANGE    = 4'd12;
    localparam logic [KEY_W-1:0] KEY_STAR      = 4'd14;
    localparam logic [KEY_W-1:0] KEY_HASH      = 4'd15;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOCKED  = 3'd0,
        MODE_ENTER   = 3'd1,
        MODE_OPEN    = 3'd2,
        MODE_LOCKOUT = 3'd3,
        MODE_REJECT  = 3'd4,
        MODE_OLD     = 3'd5,
        MODE_NEW     = 3'd6
    } mode_t;

    localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_OPENED   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_WRONG    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_LOCKOUT  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_RELOCKED = 3'd4;
    localparam logic [EVENT_W-1:0] EV_CHANGED  = 3'd5;
    localparam logic [EVENT_W-1:0] EV_OLD_BAD  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WRONG     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CARD_ID       = 2'd3;

    localparam logic [TICK_W-1:0] OPEN_TICKS_RST    = 16'd500;
    localparam logic [TICK_W-1:0] LOCKOUT_TICKS_RST = 16'd500;
    localparam logic [MISS_W-1:0] MAX_WRONG_RST     = 4'd3;
    localparam logic [UID_W-1:0]  CARD_ID_RST       = 32'h1960_C9A3;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key_code;
        logic [UID_W-1:0] card_uid;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               relay_on;
        logic               buzzer_on;
        logic [MISS_W-1:0]  wrong_tries;
        logic [ENTRY_W-1:0] entry_count;
        logic [EVENT_W-1:0] event_code;
    } status_t;

    typedef struct packed {
        logic [TICK_W-1:0] open_ticks;
        logic [TICK_W-1:0] lockout_ticks;
        logic [MISS_W-1:0] max_wrong;
        logic [UID_W-1:0]  card_id;
    } cfg_t;

endpackage

[hw/rtl/kcdl_if.sv]
// ----------------------------------------------------------------------------
// Door lock channel interfaces
// Valid/ready channels for events in and status results out.
// ----------------------------------------------------------------------------
interface kcdl_cmd_if
    import kcdl_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key_code;
    logic [UID_W-1:0] card_uid;

    modport source (output valid, op, key_code, card_uid, input ready);
    modport sink   (input valid, op, key_code, card_uid, output ready);
endinterface

interface kcdl_status_if
    import kcdl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic               relay_on;
    logic               buzzer_on;
    logic [MISS_W-1:0]  wrong_tries;
    logic [ENTRY_W-1:0] entry_count;
    logic [EVENT_W-1:0] event_code;

    modport source (output valid, mode, relay_on, buzzer_on, wrong_tries, entry_count,
                    event_code, input ready);
    modport sink   (input valid, mode, relay_on, buzzer_on, wrong_tries, entry_count,
                    event_code, output ready);
endinterface

[hw/rtl/keypad_card_door_lock_top.sv]
// ----------------------------------------------------------------------------
// Keypad and card door lock
// Top level: event input register, result register and configuration.
// ----------------------------------------------------------------------------
// The lock takes one event per transfer on cmd (key press, 10 ms tick or card
// read; op 3 is a no-op) and returns exactly one status transfer per event on
// status, carrying the mode, relay and buzzer levels, the wrong-try count, the
// entry length and an event code, all as they stand after that event. Events
// are taken at one per clock cycle while status is ready: an event sits in the
// input register while the state core evaluates it and updates the lock state,
// and its result lands in the output register; a result held in the output
// register stalls the next step until it is transferred out. The rate is set by
// the state core's combinational step, which closes the loop from one event to
// the next. The input side keeps accepting while a result waits, until both
// registers hold an item. Configuration (open_ticks, lockout_ticks, max_wrong,
// card_id at indexes 0 to 3) is written through cfg_we/cfg_index/cfg_data; the
// user must write it only while the lock is idle, as the block does not enforce
// this. The stored code resets to 1,2,3,4,5,6.
// ----------------------------------------------------------------------------
module keypad_card_door_lock_top
    import kcdl_pkg::*;
#(
    parameter int MAX_DIGITS = 9
)(
    input  logic                 clk,
    input  logic                 rst_n,
    kcdl_cmd_if.sink             cmd,
    kcdl_status_if.source        status,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cmd_t    cmd_reg;
    logic    cmd_valid_reg;
    status_t status_reg;
    logic    status_valid_reg;
    status_t step_status;
    cfg_t    cfg_reg;
    logic    adv;

    // Advance the held event when the result register is free or draining.
    assign adv       = cmd_valid_reg && (!status_valid_reg || status.ready);
    assign cmd.ready = !cmd_valid_reg || adv;

    // Input register: capture each transfer, drop the valid once consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            cmd_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg.op       <= cmd.op;
            cmd_reg.key_code <= cmd.key_code;
            cmd_reg.card_uid <= cmd.card_uid;
        end
    end

    kcdl_core #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .cmd    (cmd_reg),
        .cfg    (cfg_reg),
        .status (step_status)
    );

    // Result register: load on advance, release on transfer out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            status_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            status_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg <= step_status;
        end
    end

    assign status.valid       = status_valid_reg;
    assign status.mode        = status_reg.mode;
    assign status.relay_on    = status_reg.relay_on;
    assign status.buzzer_on   = status_reg.buzzer_on;
    assign status.wrong_tries = status_reg.wrong_tries;
    assign status.entry_count = status_reg.entry_count;
    assign status.event_code  = status_reg.event_code;

    // Configuration registers: hold reset values until written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.open_ticks    <= OPEN_TICKS_RST;
            cfg_reg.lockout_ticks <= LOCKOUT_TICKS_RST;
            cfg_reg.max_wrong     <= MAX_WRONG_RST;
            cfg_reg.card_id       <= CARD_ID_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OPEN_TICKS:    cfg_reg.open_ticks    <= cfg_data[TICK_W-1:0];
                CFG_LOCKOUT_TICKS: cfg_reg.lockout_ticks <= cfg_data[TICK_W-1:0];
                CFG_MAX_WRONG:     cfg_reg.max_wrong     <= cfg_data[MISS_W-1:0];
                CFG_CARD_ID:       cfg_reg.card_id       <= cfg_data[UID_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

[hw/rtl/kcdl_core.sv]
// ----------------------------------------------------------------------------
// Door lock state core
// Lock state registers and the combinational step for one event.
// ----------------------------------------------------------------------------
`include "keypad_card_door_lock_top_defines.svh"

module kcdl_core
    import kcdl_pkg::*;
#(
    parameter int MAX_DIGITS = 9
)(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    adv,
    input  cmd_t    cmd,
    input  cfg_t    cfg,
    output status_t status
);

    localparam int LEN_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int CODE_RST_LEN =
        (MAX_DIGITS < CODE_RST_DIGITS) ? MAX_DIGITS : CODE_RST_DIGITS;

    mode_t              mode_reg, mode_next;
    logic [KEY_W-1:0]   entry_reg [MAX_DIGITS];
    logic [KEY_W-1:0]   entry_next [MAX_DIGITS];
    logic [LEN_W-1:0]   entry_len_reg, entry_len_next;
    logic [KEY_W-1:0]   code_reg [MAX_DIGITS];
    logic [KEY_W-1:0]   code_next [MAX_DIGITS];
    logic [LEN_W-1:0]   code_len_reg, code_len_next;
    logic [MISS_W-1:0]  miss_reg, miss_next;
    logic [TICK_W-1:0]  elapsed_reg, elapsed_next;
    logic               buzz_reg, buzz_next;
    logic               relay_reg, relay_next;
    logic [EVENT_W-1:0] ev;

    logic [MAX_DIGITS-1:0] hit;
    logic                  code_match;
    logic [TICK_W-1:0]     elapsed_inc;
    logic [TICK_W-1:0]     limit;
    logic [3:0]            byte_differs;
    logic                  card_wrong;
    logic [KEY_W-1:0]      key;

    // Symbol-wise compare; positions past the entry length do not count.
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            hit[i] = (LEN_W'(i) >= entry_len_reg) || (entry_reg[i] == code_reg[i]);
        end
        code_match = (entry_len_reg == code_len_reg) && (&hit);
    end

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            byte_differs[b] = (cmd.card_uid[8*b +: 8] != 8'd0) &&
                              (cmd.card_uid[8*b +: 8] != cfg.card_id[8*b +: 8]);
        end
        card_wrong = &byte_differs;
    end

    assign elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + 16'd1 : elapsed_reg;
    assign limit       = (mode_reg == MODE_OPEN) ? cfg.open_ticks : cfg.lockout_ticks;
    assign key         = cmd.key_code;

    always_comb
    begin
        mode_next      = mode_reg;
        entry_next     = entry_reg;
        entry_len_next = entry_len_reg;
        code_next      = code_reg;
        code_len_next  = code_len_reg;
        miss_next      = miss_reg;
        elapsed_next   = elapsed_reg;
        buzz_next      = buzz_reg;
        relay_next     = relay_reg;
        ev             = EV_NONE;

        case (cmd.op)
            OP_KEY:
            begin
                if (key == KEY_CHANGE)
                begin
                    if (mode_reg != MODE_OPEN && mode_reg != MODE_LOCKOUT)
                    begin
                        entry_len_next = '0;
                        mode_next      = MODE_OLD;
                    end
                end
                else
                begin
                    case (mode_reg)
                        MODE_LOCKED:
                        begin
                            if (key == KEY_STAR)
                            begin
                                mode_next = MODE_ENTER;
                            end
                        end
                        MODE_ENTER, MODE_OLD, MODE_NEW:
                        begin
                            if (key == KEY_CLEAR)
                            begin
                                entry_len_next = '0;
                            end
                            else if (key == KEY_BACK)
                            begin
                                if (entry_len_reg != '0)
                                begin
                                    entry_len_next = entry_len_reg - 1'b1;
                                end
                            end
                            else if (key == KEY_HASH)
                            begin
                                entry_len_next = '0;
                                if (mode_reg == MODE_ENTER)
                                begin
                                    if (code_match)
                                    begin
                                        mode_next    = MODE_OPEN;
                                        relay_next   = 1'b1;
                                        elapsed_next = '0;
                                        miss_next    = '0;
                                        ev           = EV_OPENED;
                                    end
                                    else if (miss_reg < cfg.max_wrong)
                                    begin
                                        miss_next = miss_reg + 1'b1;
                                        ev        = EV_WRONG;
                                    end
                                    else
                                    begin
                                        mode_next    = MODE_LOCKOUT;
                                        elapsed_next = '0;
                                        ev           = EV_LOCKOUT;
                                    end
                                end
                                else if (mode_reg == MODE_OLD)
                                begin
                                    if (code_match)
                                    begin
                                        mode_next = MODE_NEW;
                                    end
                                    else
                                    begin
                                        mode_next = MODE_LOCKED;
                                        ev        = EV_OLD_BAD;
                                    end
                                end
                                else
                                begin
                                    // An empty new code keeps the stored one.
                                    if (entry_len_reg != '0)
                                    begin
                                        code_next     = entry_reg;
                                        code_len_next = entry_len_reg;
                                        ev            = EV_CHANGED;
                                    end
                                    mode_next = MODE_LOCKED;
                                end
                            end
                            else if (mode_reg == MODE_ENTER || key <= KEY_DIGIT_MAX)
                            begin
                                if (entry_len_reg < LEN_W'(MAX_DIGITS))
                                begin
                                    entry_next[entry_len_reg[IDX_W-1:0]] = key;
                                    entry_len_next = entry_len_reg + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            OP_TICK:
            begin
                if (mode_reg == MODE_OPEN || mode_reg == MODE_LOCKOUT)
                begin
                    buzz_next    = ~buzz_reg;
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= limit)
                    begin
                        buzz_next = 1'b0;
                        mode_next = MODE_LOCKED;
                        if (mode_reg == MODE_OPEN)
                        begin
                            relay_next = 1'b0;
                            ev         = EV_RELOCKED;
                        end
                    end
                end
                else if (mode_reg == MODE_REJECT)
                begin
                    mode_next = MODE_LOCKED;
                end
            end
            OP_CARD:
            begin
                if (mode_reg != MODE_LOCKOUT)
                begin
                    if (cmd.card_uid == cfg.card_id)
                    begin
                        entry_len_next = '0;
                        mode_next      = MODE_OPEN;
                        relay_next     = 1'b1;
                        elapsed_next   = '0;
                        miss_next      = '0;
                        ev             = EV_OPENED;
                    end
                    else if (card_wrong && mode_reg != MODE_OPEN)
                    begin
                        if (miss_reg < cfg.max_wrong)
                        begin
                            miss_next = miss_reg + 1'b1;
                            mode_next = MODE_REJECT;
                            ev        = EV_WRONG;
                        end
                        else
                        begin
                            mode_next    = MODE_LOCKOUT;
                            elapsed_next = '0;
                            ev           = EV_LOCKOUT;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result reflects the state after this event.
    always_comb
    begin
        status.mode        = mode_next;
        status.relay_on    = relay_next;
        status.buzzer_on   = buzz_next;
        status.wrong_tries = miss_next;
        status.entry_count = ENTRY_W'(entry_len_next);
        status.event_code  = ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_LOCKED;
            entry_len_reg <= '0;
            code_len_reg  <= LEN_W'(CODE_RST_LEN);
            miss_reg      <= '0;
            elapsed_reg   <= '0;
            buzz_reg      <= 1'b0;
            relay_reg     <= 1'b0;
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                code_reg[i] <= (i < CODE_RST_DIGITS) ? KEY_W'(i + 1) : '0;
            end
        end
        else if (adv)
        begin
            mode_reg      <= mode_next;
            entry_len_reg <= entry_len_next;
            code_len_reg  <= code_len_next;
            miss_reg      <= miss_next;
            elapsed_reg   <= elapsed_next;
            buzz_reg      <= buzz_next;
            relay_reg     <= relay_next;
            code_reg      <= code_next;
        end
    end

    // Entry symbols carry no reset; only positions below the length are read.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            entry_reg <= entry_next;
        end
    end

    `KCDL_ASSERT_ALWAYS(a_relay_iff_open, relay_reg == (mode_reg == MODE_OPEN), "relay and open mode disagree")
    `KCDL_ASSERT_ALWAYS(a_buzz_mode, !buzz_reg || mode_reg == MODE_OPEN || mode_reg == MODE_LOCKOUT, "buzzer on outside open or lockout")
    `KCDL_ASSERT_ALWAYS(a_entry_bound, entry_len_reg <= LEN_W'(MAX_DIGITS), "entry length beyond capacity")
    `KCDL_ASSERT_NEXT(a_hold_idle, !adv, $stable(mode_reg) && $stable(miss_reg), "lock state moved without an event")

endmodule
